>>> src/arte_pkg.sv
// package for the route table engine: codes, widths, result type
`timescale 1ns / 1ps
package arte_pkg;
	localparam int AddrW = 48;
	localparam int HopW = 8;
	localparam int DefDepth = 16;
	localparam logic [AddrW-1:0] AddrOnes = {AddrW{1'b1}};
	localparam logic [HopW-1:0] HopMax = {HopW{1'b1}};

	typedef enum logic [2:0] {
		REQ_RREQ = 3'd0, REQ_RREP = 3'd1, REQ_DATA = 3'd2,
		REQ_RERR = 3'd3, REQ_HELLO = 3'd4, REQ_TICK = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ACT_FWD_DATA = 3'd0, ACT_DELIVER = 3'd1, ACT_SEND_RREP = 3'd2,
		ACT_REBCAST = 3'd3, ACT_FWD_RREP = 3'd4, ACT_RERR = 3'd5
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_DECIDE, ST_EMIT1, ST_WRITE,
		ST_TICK_RD, ST_TICK, ST_ERR_RD, ST_ERR, ST_ERR_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [AddrW-1:0] to_addr;
		logic [AddrW-1:0] out_source;
		logic [AddrW-1:0] out_dest;
		logic [HopW-1:0] out_hops;
		logic last;
	} res_t;

	function automatic logic [HopW-1:0] sat_inc(input logic [HopW-1:0] h);
		sat_inc = (h == HopMax) ? HopMax : h + 1'b1;
	endfunction
endpackage

>>> src/arte_out_reg.sv
// output register holding one result for the master side
`timescale 1ns / 1ps
module arte_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  arte_pkg::res_t push_data,
	output logic full,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output arte_pkg::res_t data
);
	import arte_pkg::*;
	res_t data_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign full = valid_q && !m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign data = data_q;
endmodule

>>> src/adhoc_route_table_engine.sv
// top level of the ad hoc route table engine
//
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: src, dst, sender, hops; tuser: req_type
// m_axis    | out | m_axis_tvalid/tready   | tdata: to, source, dest, hops; tuser: action; tlast
// cfg       | in  | cfg_we                 | cfg_wdata: self_addr
//
// one request at a time: s_axis_tready is high only in idle; a lookup/learn/hello/rerr scans the table,
// data for this node goes straight to output, ignored requests and unused kinds stay in idle
// tick ages slots past slot 0, then walks the table; if a route was lost, a rerr walk over those slots follows
// reset clears control and heard bits, sets only slot 0 valid and the count to 1; table memory is not cleared
// a full output register holds the emit states until it drains; it lets the engine move on while one result waits
`timescale 1ns / 1ps
module adhoc_route_table_engine #(
	parameter int TABLE_DEPTH = arte_pkg::DefDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [arte_pkg::AddrW-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [151:0] s_axis_tdata,  // orig_addr, dst_addr, sender_addr, hops
	input  logic [2:0] s_axis_tuser,    // req_type
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [151:0] m_axis_tdata,  // to_addr, out_source, out_dest, out_hops
	output logic [2:0] m_axis_tuser,    // action
	output logic m_axis_tlast
);
	import arte_pkg::*;
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	// route memory: dest, next hop, hop count in one word
	logic [2*AddrW+HopW-1:0] mem [TABLE_DEPTH];
	logic [2*AddrW+HopW-1:0] rd_q;
	logic [TABLE_DEPTH-1:0] valid_q, heard_q;
	logic [CW-1:0] count_q;
	logic [AddrW-1:0] self_q;

	// request registers
	logic [2:0] typ_q;
	logic [AddrW-1:0] src_q, dst_q, snd_q;
	logic [HopW-1:0] hops_q;

	state_t st_q, st_d;
	logic [CW-1:0] idx_q;   // address being read
	logic [CW-1:0] cmp_q;   // entry whose data is in rd_q
	// scan results
	logic fv_hit_q; logic [AddrW-1:0] fv_next_q; logic [HopW-1:0] fv_hops_q;
	logic fa_hit_q; logic [IW-1:0] fa_idx_q; logic fa_valid_q; logic [HopW-1:0] fa_hops_q;
	logic nh_hit_q;
	logic changed_q;
	logic [CW-1:0] last_inv_q;

	logic out_full, push;
	res_t push_d, out_d;

	logic [AddrW-1:0] r_dest, r_next;
	logic [HopW-1:0] r_hops;
	assign {r_dest, r_next, r_hops} = rd_q;
	logic [IW-1:0] cidx;
	assign cidx = cmp_q[IW-1:0];

	// slot 0 lives outside memory: always self
	logic [AddrW-1:0] e_dest, e_next;
	logic [HopW-1:0] e_hops;
	always_comb begin
		if (cmp_q == '0) begin
			e_dest = self_q; e_next = self_q; e_hops = '0;
		end else begin
			e_dest = r_dest; e_next = r_next; e_hops = r_hops;
		end
	end

	logic accept;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	logic scan_end;
	assign scan_end = (idx_q == count_q) || (idx_q == DepthC);
	// rerr walk: the entry being emitted is the last one in the table
	logic err_end;
	assign err_end = ((idx_q + CW'(1)) == count_q);

	// aging summary: any valid route lost, and the highest slot left invalid
	logic tick_chg;
	logic [CW-1:0] tick_last;
	always_comb begin
		tick_chg = 1'b0;
		tick_last = '0;
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			if (CW'(i) < count_q && !heard_q[i]) begin
				tick_last = CW'(i);
				if (valid_q[i]) tick_chg = 1'b1;
			end
		end
	end

	// write decision for the learn/hello phase
	logic [AddrW-1:0] ldst, lnext;
	logic [HopW-1:0] lhops;
	logic learn_en, do_wr, do_ins;
	always_comb begin
		learn_en = 1'b0;
		ldst = src_q; lnext = snd_q; lhops = hops_q;
		case (typ_q)
			REQ_RREQ, REQ_RREP: learn_en = (src_q != self_q);
			REQ_HELLO: begin
				learn_en = !nh_hit_q; lnext = src_q; lhops = HopW'(1);
			end
			default: learn_en = 1'b0;
		endcase
		do_wr = learn_en && fa_hit_q &&
			((typ_q == REQ_HELLO) || !fa_valid_q || (fa_hops_q > lhops));
		do_ins = learn_en && !fa_hit_q && (count_q < DepthC);
	end
	logic [IW-1:0] wr_idx;
	assign wr_idx = do_ins ? count_q[IW-1:0] : fa_idx_q;

	// rrep toward its own originator: the route just learned carries it
	logic rrep_learned;
	assign rrep_learned = (src_q == dst_q) && (do_wr || do_ins);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (accept) begin
				case (s_axis_tuser)
					REQ_RREQ, REQ_HELLO: st_d = (s_axis_tdata[47:0] == self_q) ?
						ST_IDLE : ST_SCAN_RD;
					REQ_RREP, REQ_RERR: st_d = ST_SCAN_RD;
					REQ_DATA: st_d = (s_axis_tdata[95:48] == self_q) ? ST_EMIT1 : ST_SCAN_RD;
					REQ_TICK: st_d = ST_TICK_RD;
					default: st_d = ST_IDLE;
				endcase
			end
			ST_SCAN_RD: st_d = ST_SCAN;
			ST_SCAN: if (scan_end) st_d = ST_DECIDE;
			ST_DECIDE: st_d = ST_EMIT1;
			ST_EMIT1: if (!out_full) st_d = ST_WRITE;
			ST_WRITE: st_d = ST_IDLE;
			ST_TICK_RD: st_d = ST_TICK;
			ST_TICK: if (scan_end) st_d = changed_q ? ST_ERR_RD : ST_IDLE;
			ST_ERR_RD: st_d = ST_ERR;
			ST_ERR: st_d = ST_ERR_OUT;
			ST_ERR_OUT: if (!out_full) st_d = err_end ? ST_IDLE : ST_ERR;
			default: st_d = ST_IDLE;
		endcase
	end

	// result to push
	always_comb begin
		push = 1'b0;
		push_d = '0;
		push_d.last = 1'b1;
		case (st_q)
			ST_EMIT1: if (!out_full) begin
				push_d.out_source = src_q; push_d.out_dest = dst_q;
				push_d.out_hops = sat_inc(hops_q);
				case (typ_q)
					REQ_RREQ: begin
						push = 1'b1;
						if (fv_hit_q) begin
							push_d.action = ACT_SEND_RREP; push_d.to_addr = snd_q;
							push_d.out_source = dst_q; push_d.out_dest = src_q;
							push_d.out_hops = sat_inc(fv_hops_q);
						end else begin
							push_d.action = ACT_REBCAST; push_d.to_addr = AddrOnes;
						end
					end
					REQ_RREP: begin
						push = (fv_hit_q || rrep_learned) && (dst_q != self_q);
						push_d.action = ACT_FWD_RREP;
						push_d.to_addr = rrep_learned ? snd_q : fv_next_q;
					end
					REQ_DATA: begin
						if (dst_q == self_q) begin
							push = 1'b1; push_d.action = ACT_DELIVER;
							push_d.to_addr = self_q; push_d.out_hops = hops_q;
						end else begin
							push = fv_hit_q; push_d.action = ACT_FWD_DATA;
							push_d.to_addr = fv_next_q;
						end
					end
					default: push = 1'b0;
				endcase
			end
			ST_ERR_OUT: if (!out_full) begin
				push = !valid_q[cidx];
				push_d.action = ACT_RERR; push_d.to_addr = AddrOnes;
				push_d.out_source = self_q; push_d.out_dest = e_next;
				push_d.out_hops = '0;
				push_d.last = (cmp_q == last_inv_q);
			end
			default: push = 1'b0;
		endcase
	end

	// memory: one read port, one write port, registered read
	logic [IW-1:0] raddr;
	assign raddr = idx_q[IW-1:0];
	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (st_q == ST_WRITE && (do_wr || do_ins)) begin
			mem[wr_idx] <= {ldst, lnext, lhops};
		end
	end

	logic rd_adv;
	assign rd_adv = (st_q == ST_SCAN_RD) || (st_q == ST_TICK_RD) ||
		(st_q == ST_SCAN && !scan_end) || (st_q == ST_TICK && !scan_end);

	always_ff @(posedge clk) begin
		if (accept) begin
			typ_q <= s_axis_tuser;
			src_q <= s_axis_tdata[47:0];
			dst_q <= s_axis_tdata[95:48];
			snd_q <= s_axis_tdata[143:96];
			hops_q <= s_axis_tdata[151:144];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			self_q <= '0;
			valid_q <= {{(TABLE_DEPTH-1){1'b0}}, 1'b1};
			heard_q <= '0;
			count_q <= CW'(1);
			idx_q <= '0; cmp_q <= '0;
			fv_hit_q <= 1'b0; fa_hit_q <= 1'b0; nh_hit_q <= 1'b0;
			fv_next_q <= '0; fv_hops_q <= '0; fa_idx_q <= '0; fa_valid_q <= 1'b0;
			fa_hops_q <= '0; changed_q <= 1'b0; last_inv_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) self_q <= cfg_wdata;
			if (accept) begin
				idx_q <= '0; fv_hit_q <= 1'b0; fa_hit_q <= 1'b0;
				nh_hit_q <= 1'b0; changed_q <= 1'b0;
			end
			if (rd_adv) begin
				cmp_q <= idx_q;
				idx_q <= idx_q + 1'b1;
			end
			// compare the entry just read
			if (st_q == ST_SCAN && !scan_end && cmp_q < idx_q) begin
				if (!fv_hit_q && valid_q[cidx] && e_dest == dst_q) begin
					fv_hit_q <= 1'b1; fv_next_q <= e_next; fv_hops_q <= e_hops;
				end
				if (cmp_q != '0) begin
					if (!fa_hit_q && r_dest == src_q) begin
						fa_hit_q <= 1'b1; fa_idx_q <= cidx;
						fa_valid_q <= valid_q[cidx]; fa_hops_q <= r_hops;
					end
					if (typ_q == REQ_RERR && (r_next == dst_q || r_dest == dst_q))
						valid_q[cidx] <= 1'b0;
					if (typ_q == REQ_HELLO && r_next == src_q) begin
						heard_q[cidx] <= 1'b1; nh_hit_q <= 1'b1;
					end
				end
			end
			if (st_q == ST_SCAN && scan_end && cmp_q < idx_q) begin
				// last entry: same compare as above
				if (!fv_hit_q && valid_q[cidx] && e_dest == dst_q) begin
					fv_hit_q <= 1'b1; fv_next_q <= e_next; fv_hops_q <= e_hops;
				end
				if (cmp_q != '0) begin
					if (!fa_hit_q && r_dest == src_q) begin
						fa_hit_q <= 1'b1; fa_idx_q <= cidx;
						fa_valid_q <= valid_q[cidx]; fa_hops_q <= r_hops;
					end
					if (typ_q == REQ_RERR && (r_next == dst_q || r_dest == dst_q))
						valid_q[cidx] <= 1'b0;
					if (typ_q == REQ_HELLO && r_next == src_q) begin
						heard_q[cidx] <= 1'b1; nh_hit_q <= 1'b1;
					end
				end
				cmp_q <= idx_q;
			end
			if (st_q == ST_WRITE && (do_wr || do_ins)) begin
				valid_q[wr_idx] <= 1'b1;
				if (do_ins) begin
					heard_q[wr_idx] <= 1'b0;
					count_q <= count_q + 1'b1;
				end
			end
			// tick: aging is per bit, no memory data needed
			if (st_q == ST_TICK_RD) begin
				for (int i = 1; i < TABLE_DEPTH; i++) begin
					if (CW'(i) < count_q) valid_q[i] <= heard_q[i];
				end
				changed_q <= tick_chg;
				last_inv_q <= tick_last;
				heard_q <= '0;
			end
			if (st_q == ST_TICK && scan_end) begin
				idx_q <= CW'(1);
			end
			// rerr walk: idx holds the entry, so rd_q stays put through output stalls
			if (st_q == ST_ERR) begin
				cmp_q <= idx_q;
			end
			if (st_q == ST_ERR_OUT && !out_full && !err_end) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	arte_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_d), .full(out_full),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .data(out_d)
	);
	assign m_axis_tdata = {out_d.out_hops, out_d.out_dest, out_d.out_source, out_d.to_addr};
	assign m_axis_tuser = out_d.action;
	assign m_axis_tlast = out_d.last;
endmodule

>>> tb/sv/route_table_checker.sv
// route table checker: watches the request and result channels, predicts and compares
`timescale 1ns / 1ps
module route_table_checker #(
	parameter int DEPTH = arte_pkg::DefDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [arte_pkg::AddrW-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [151:0] s_axis_tdata,
	input  logic [2:0] s_axis_tuser,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [151:0] m_axis_tdata,
	input  logic [2:0] m_axis_tuser,
	input  logic m_axis_tlast,
	output int fail_count,
	output int pending
);
	import arte_pkg::*;
	logic [AddrW-1:0] node_addr;
	logic [AddrW-1:0] tbl_dest [DEPTH];
	logic [AddrW-1:0] tbl_next [DEPTH];
	logic [HopW-1:0] tbl_hops [DEPTH];
	logic tbl_valid [DEPTH];
	logic tbl_heard [DEPTH];
	int tbl_count;
	res_t route_results [$];

	function automatic logic [HopW-1:0] hop_up(input logic [HopW-1:0] h);
		hop_up = (h == HopMax) ? HopMax : h + 8'd1;
	endfunction

	function automatic int lookup_valid(input logic [AddrW-1:0] a);
		lookup_valid = -1;
		for (int i = tbl_count - 1; i >= 0; i--)
			if (tbl_valid[i] && tbl_dest[i] == a) lookup_valid = i;
	endfunction

	function automatic int lookup_any(input logic [AddrW-1:0] a);
		lookup_any = -1;
		for (int i = tbl_count - 1; i >= 1; i--)
			if (tbl_dest[i] == a) lookup_any = i;
	endfunction

	task automatic set_slot(input int k, input logic [AddrW-1:0] d,
			input logic [AddrW-1:0] nx, input logic [HopW-1:0] h);
		tbl_dest[k] = d;
		tbl_next[k] = nx;
		tbl_hops[k] = h;
		tbl_valid[k] = 1'b1;
	endtask

	task automatic add_slot(input logic [AddrW-1:0] d, input logic [AddrW-1:0] nx,
			input logic [HopW-1:0] h);
		if (tbl_count < DEPTH) begin
			set_slot(tbl_count, d, nx, h);
			tbl_heard[tbl_count] = 1'b0;
			tbl_count++;
		end
	endtask

	task automatic learn_route(input logic [AddrW-1:0] d, input logic [AddrW-1:0] nx,
			input logic [HopW-1:0] h);
		int k;
		if (d != node_addr) begin
			k = lookup_any(d);
			if (k < 0) add_slot(d, nx, h);
			else if (!tbl_valid[k] || tbl_hops[k] > h) set_slot(k, d, nx, h);
		end
	endtask

	task automatic push_result(input act_t act, input logic [AddrW-1:0] to,
			input logic [AddrW-1:0] s, input logic [AddrW-1:0] d, input logic [HopW-1:0] h);
		res_t r;
		r.action = act;
		r.to_addr = to;
		r.out_source = s;
		r.out_dest = d;
		r.out_hops = h;
		r.last = 1'b0;
		route_results.push_back(r);
	endtask

	task automatic predict_request(input logic [2:0] kind, input logic [151:0] data);
		logic [AddrW-1:0] src, dst, snd;
		logic [HopW-1:0] hops;
		int k, before_n;
		bit found, changed;
		src = data[47:0];
		dst = data[95:48];
		snd = data[143:96];
		hops = data[151:144];
		before_n = route_results.size();
		found = 0;
		changed = 0;
		case (kind)
			REQ_RREQ: begin
				if (src != node_addr) begin
					k = lookup_valid(dst);
					if (k >= 0) push_result(ACT_SEND_RREP, snd, dst, src, hop_up(tbl_hops[k]));
					else push_result(ACT_REBCAST, AddrOnes, src, dst, hop_up(hops));
					learn_route(src, snd, hops);
				end
			end
			REQ_RREP: begin
				learn_route(src, snd, hops);
				if (dst != node_addr) begin
					k = lookup_valid(dst);
					if (k >= 0) push_result(ACT_FWD_RREP, tbl_next[k], src, dst, hop_up(hops));
				end
			end
			REQ_DATA: begin
				if (dst == node_addr) push_result(ACT_DELIVER, node_addr, src, dst, hops);
				else begin
					k = lookup_valid(dst);
					if (k >= 0) push_result(ACT_FWD_DATA, tbl_next[k], src, dst, hop_up(hops));
				end
			end
			REQ_RERR: begin
				for (int i = 1; i < tbl_count; i++)
					if (tbl_next[i] == dst || tbl_dest[i] == dst) tbl_valid[i] = 1'b0;
			end
			REQ_HELLO: begin
				if (src != node_addr) begin
					for (int i = 1; i < tbl_count; i++)
						if (tbl_next[i] == src) begin
							tbl_heard[i] = 1'b1;
							found = 1;
						end
					if (!found) begin
						k = lookup_any(src);
						if (k >= 0) set_slot(k, src, src, 8'd1);
						else add_slot(src, src, 8'd1);
					end
				end
			end
			REQ_TICK: begin
				for (int i = 1; i < tbl_count; i++) begin
					if (tbl_heard[i]) tbl_valid[i] = 1'b1;
					else begin
						if (tbl_valid[i]) changed = 1;
						tbl_valid[i] = 1'b0;
					end
				end
				if (changed)
					for (int i = 1; i < tbl_count; i++)
						if (!tbl_valid[i])
							push_result(ACT_RERR, AddrOnes, node_addr, tbl_next[i], '0);
				for (int i = 0; i < DEPTH; i++) tbl_heard[i] = 1'b0;
			end
			default: ;
		endcase
		if (route_results.size() > before_n)
			route_results[route_results.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [AddrW-1:0] exp_v,
			input logic [AddrW-1:0] act_v, inout bit bad);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			bad = 1;
		end
	endtask

	// handshakes sampled mid-cycle: values here are those seen at the next rising edge
	always @(negedge clk) begin
		res_t want;
		bit bad;
		if (!arst_n) begin
			node_addr = '0;
			for (int i = 0; i < DEPTH; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_heard[i] = 1'b0;
			end
			tbl_valid[0] = 1'b1;
			tbl_count = 1;
			route_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				node_addr = cfg_wdata;
				set_slot(0, cfg_wdata, cfg_wdata, '0);
			end
			if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (route_results.size() == 0) begin
					$error("unexpected result: action %0d to %0h", m_axis_tuser,
						m_axis_tdata[47:0]);
					fail_count++;
				end else begin
					want = route_results.pop_front();
					bad = 0;
					check_field("action", AddrW'(want.action), AddrW'(m_axis_tuser), bad);
					check_field("to_addr", want.to_addr, m_axis_tdata[47:0], bad);
					check_field("out_source", want.out_source, m_axis_tdata[95:48], bad);
					check_field("out_dest", want.out_dest, m_axis_tdata[143:96], bad);
					check_field("out_hops", AddrW'(want.out_hops),
						AddrW'(m_axis_tdata[151:144]), bad);
					check_field("last", AddrW'(want.last), AddrW'(m_axis_tlast), bad);
					if (bad) fail_count++;
				end
			end
		end
		pending = route_results.size();
	end
endmodule

>>> tb/sv/adhoc_route_table_engine_tb.sv
// testbench top for the route table engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module adhoc_route_table_engine_tb;
	import arte_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [AddrW-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [151:0] s_axis_tdata = '0;  // orig_addr, dst_addr, sender_addr, hops
	logic [2:0] s_axis_tuser = '0;    // req_type
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;       // to_addr, out_source, out_dest, out_hops
	logic [2:0] m_axis_tuser;         // action
	logic m_axis_tlast;
	int fail_count;
	int pending;
	int stall_cycles = 0;
	bit steady = 0;                   // long stretch without idling on either side
	logic [AddrW-1:0] self_now = '0;
	logic [AddrW-1:0] nodes [8];

	always #5 clk = ~clk;

	adhoc_route_table_engine dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	route_table_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast), .fail_count(fail_count), .pending(pending)
	);

	// result side backpressure, about one cycle in ten
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 10);
	end

	// watchdog on cycles without any accepted request or result
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles > 20000) begin
				$display("adhoc_route_table_engine verification failed");
				$finish;
			end
		end
	end

	function automatic logic [AddrW-1:0] any_addr();
		any_addr = AddrW'({$urandom, $urandom});
	endfunction

	// mostly known nodes so routes hit, some self and some fresh addresses
	function automatic logic [AddrW-1:0] pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 70) pick_addr = nodes[$urandom_range(7)];
		else if (r < 80) pick_addr = self_now;
		else pick_addr = any_addr();
	endfunction

	function automatic logic [HopW-1:0] pick_hops();
		int r;
		r = $urandom_range(99);
		if (r < 70) pick_hops = HopW'($urandom_range(6));
		else if (r < 85) pick_hops = HopMax - HopW'($urandom_range(1));
		else pick_hops = HopW'($urandom_range(255));
	endfunction

	// hold one request until it is taken; valid stays up for a back-to-back follower
	task automatic send_request(input logic [2:0] kind, input logic [AddrW-1:0] src,
			input logic [AddrW-1:0] dst, input logic [AddrW-1:0] snd, input logic [HopW-1:0] hops);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {hops, snd, dst, src};
		forever begin
			@(negedge clk);
			if (s_axis_tready) break;
		end
		@(posedge clk);
		if (!steady && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drain all results, then give the walk that may make no result time to end
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_self(input logic [AddrW-1:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		self_now = a;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [AddrW-1:0] na, nb, nc;
		logic [2:0] kind;
		int r;
		for (int i = 0; i < 8; i++) nodes[i] = any_addr();
		nodes[6] = AddrOnes - 48'd1;
		nodes[7] = 48'h1;
		na = nodes[0];
		nb = nodes[1];
		nc = nodes[2];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// self slot must hold a defined address before any lookup
		write_self('0);

		// directed: every request kind, self addressing, saturation, aging
		send_request(REQ_HELLO, self_now, na, na, 8'd0);        // hello from self, ignored
		send_request(REQ_HELLO, na, nb, nc, 8'd7);              // new neighbor
		send_request(REQ_RREQ, nb, nc, na, 8'd2);               // no route, rebroadcast
		send_request(REQ_RREQ, nc, na, na, HopMax);             // route known, send rrep
		send_request(REQ_RREQ, self_now, na, nb, 8'd1);         // own rreq, ignored
		send_request(REQ_RREQ, nb, self_now, na, 8'd0);         // route to self
		send_request(REQ_RREP, nc, nb, na, 8'd1);               // forward rrep
		send_request(REQ_RREP, nb, self_now, na, 8'd1);         // rrep for us, learn only
		send_request(REQ_RREP, any_addr(), any_addr(), na, 8'd3); // no route onward
		send_request(REQ_DATA, nb, self_now, na, HopMax);       // deliver
		send_request(REQ_DATA, self_now, nb, na, HopMax);       // forward, saturated
		send_request(REQ_DATA, nb, AddrOnes, '0, 8'd4);         // no route, dropped
		send_request(REQ_HELLO, na, '0, '0, 8'd0);              // marks slots via na heard
		send_request(REQ_TICK, '0, '0, '0, 8'd0);               // heard, nothing lost
		send_request(REQ_TICK, AddrOnes, AddrOnes, AddrOnes, HopMax); // all aged out
		send_request(REQ_HELLO, na, '0, '0, 8'd0);              // stale entries marked heard, not relearned
		send_request(REQ_RERR, '0, na, '0, 8'd0);               // invalidate via na
		send_request(3'd6, na, nb, nc, 8'd1);                   // unused kinds
		send_request(3'd7, AddrOnes, AddrOnes, AddrOnes, HopMax);
		send_request(REQ_RREQ, AddrOnes, '0, AddrOnes, 8'd5);
		send_request(REQ_RREQ, AddrOnes, nb, nc, 8'd1);         // better hop count
		drain();
		write_self(AddrOnes);

		// random: mostly well formed traffic among known nodes
		for (int n = 0; n < 80; n++) begin
			if (n == 30 || n == 65) begin
				drain();
				write_self(n == 30 ? any_addr() : nodes[$urandom_range(7)]);
			end
			steady = (n >= 40 && n < 60);
			r = $urandom_range(99);
			if (r < 22) kind = REQ_HELLO;
			else if (r < 42) kind = REQ_RREQ;
			else if (r < 57) kind = REQ_RREP;
			else if (r < 77) kind = REQ_DATA;
			else if (r < 85) kind = REQ_RERR;
			else if (r < 96) kind = REQ_TICK;
			else kind = 3'($urandom_range(7));
			send_request(kind, pick_addr(), pick_addr(), pick_addr(), pick_hops());
		end
		steady = 0;
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("adhoc_route_table_engine verification clean");
		end else begin
			$display("adhoc_route_table_engine verification failed");
		end
		$finish;
	end
endmodule

>>> adhoc_route_table_engine.f
src/arte_pkg.sv
src/arte_out_reg.sv
src/adhoc_route_table_engine.sv
tb/sv/route_table_checker.sv
tb/sv/adhoc_route_table_engine_tb.sv
